// File: rtl/core/ptl_pkg.sv
// Package for the page table translate/load block.
// Field widths, response codes, page geometry and the stats types.
// No dependencies.
package ptl_pkg;

    localparam int VA_W        = 20;
    localparam int PAGE_IDX_W  = 4;
    localparam int FRAME_IDX_W = 3;
    localparam int PA_W        = 15;
    localparam int CNT_W       = 32;

    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

    localparam int NUM_FRAMES_DEF = 8;
    localparam int NUM_PAGES_DEF  = 16;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_HIT     = 2'd0;
    localparam status_t STATUS_FAULT   = 2'd1;
    localparam status_t STATUS_INVALID = 2'd2;
    localparam status_t STATUS_LOADED  = 2'd3;

    typedef struct packed {
        logic hit;
        logic fault;
    } stat_evt_t;

    typedef struct packed {
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] faults;
    } stat_cnt_t;

endpackage

// File: rtl/core/ptl_req_if.sv
// Request channel: valid/ready handshake carrying one translate or load transaction.
// Depends on ptl_pkg.
interface ptl_req_if
    import ptl_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [VA_W-1:0]        vaddr;
    logic [PAGE_IDX_W-1:0]  load_page_index;
    logic [FRAME_IDX_W-1:0] load_frame_index;

    modport source (
        output valid, kind, vaddr, load_page_index, load_frame_index,
        input  ready
    );

    modport sink (
        input  valid, kind, vaddr, load_page_index, load_frame_index,
        output ready
    );
endinterface

// File: rtl/core/ptl_rsp_if.sv
// Response channel: valid/ready handshake carrying one result transaction.
// Depends on ptl_pkg.
interface ptl_rsp_if
    import ptl_pkg::*;
();
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [PA_W-1:0]       physical_address;
    logic                  evicted_valid;
    logic [PAGE_IDX_W-1:0] evicted_page;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      fault_total;

    modport source (
        output valid, status, physical_address, evicted_valid, evicted_page,
               hit_total, fault_total,
        input  ready
    );

    modport sink (
        input  valid, status, physical_address, evicted_valid, evicted_page,
               hit_total, fault_total,
        output ready
    );
endinterface

// File: rtl/core/ptl_stats.sv
// Saturating hit and fault counters for the page table block.
// Depends on ptl_pkg.
module ptl_stats
    import ptl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  stat_evt_t evt,
    output stat_cnt_t cnt_next
);

    stat_cnt_t cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (evt.hit && (cnt_reg.hits != '1))
        begin
            cnt_next.hits = cnt_reg.hits + 1'b1;
        end
        if (evt.fault && (cnt_reg.faults != '1))
        begin
            cnt_next.faults = cnt_reg.faults + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        !(evt.hit && evt.fault))
        else $error("hit and fault in the same cycle");

    a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg.hits >= $past(cnt_reg.hits))
        else $error("hit counter decreased");

    a_faults_mono: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg.faults >= $past(cnt_reg.faults))
        else $error("fault counter decreased");

endmodule

// File: rtl/core/page_table_translate_load.sv
// Page table translate/load top level. Depends on ptl_pkg, ptl_req_if, ptl_rsp_if, ptl_stats.
// Sequence: a translate or invalid request goes S_IDLE -> S_LOOK, a load S_IDLE -> S_UNMAP
// -> S_MAP; the result is registered into the response register, and S_LOOK and S_MAP
// wait while that register holds an untaken response. A new request is accepted only in S_IDLE.
// Reset: counters cleared; a clearing pass over max(NUM_PAGES, NUM_FRAMES) entries then
// zeroes both memories, during which no request is accepted.
module page_table_translate_load
    import ptl_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int NUM_PAGES  = NUM_PAGES_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    ptl_req_if.sink   req,
    ptl_rsp_if.source rsp
);

    localparam int FW        = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int PIW       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CLR_DEPTH = (NUM_PAGES > NUM_FRAMES) ? NUM_PAGES : NUM_FRAMES;
    localparam int CW        = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_UNMAP = 3'd3;
    localparam logic [2:0] S_MAP   = 3'd4;

    typedef struct packed {
        logic          present;
        logic [FW-1:0] frame;
    } pte_t;

    typedef struct packed {
        logic           valid;
        logic [PIW-1:0] page;
    } fte_t;

    pte_t page_mem [NUM_PAGES];
    fte_t frame_mem [NUM_FRAMES];

    pte_t           page_rd_reg;
    fte_t           frame_rd_reg;
    logic           page_we;
    logic           page_re;
    logic [PIW-1:0] page_waddr;
    logic [PIW-1:0] page_raddr;
    pte_t           page_wdata;
    logic           frame_we;
    logic           frame_re;
    logic [FW-1:0]  frame_waddr;
    logic [FW-1:0]  frame_raddr;
    fte_t           frame_wdata;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] clr_idx_reg;
    logic [CW-1:0] clr_idx_next;

    logic                  bad_reg;
    logic [PAGE_SHIFT-1:0] offset_reg;
    logic [PIW-1:0]        lpage_reg;
    logic [FW-1:0]         lframe_reg;

    logic                  out_valid_reg;
    status_t               status_reg;
    logic [PA_W-1:0]       phys_reg;
    logic                  ev_valid_reg;
    logic [PAGE_IDX_W-1:0] ev_page_reg;
    logic [CNT_W-1:0]      hit_total_reg;
    logic [CNT_W-1:0]      fault_total_reg;

    logic                  load_out;
    status_t               o_status;
    logic [PA_W-1:0]       o_phys;
    logic                  o_ev_valid;
    logic [PAGE_IDX_W-1:0] o_ev_page;

    stat_evt_t evt;
    stat_cnt_t cnt_next;

    logic                    accept;
    logic                    out_free;
    logic [VA_W-PAGE_SHIFT-1:0] vpn;
    logic [31:0]             vpn_ext;
    logic [31:0]             lpage_ext;
    logic [31:0]             lframe_ext;
    logic [31:0]             clr_ext;
    logic [31:0]             ev_ext;
    logic [31:0]             phys_ext;
    logic                    req_bad;

    assign accept     = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign vpn        = req.vaddr[VA_W-1:PAGE_SHIFT];
    assign vpn_ext    = 32'(vpn);
    assign lpage_ext  = 32'(req.load_page_index);
    assign lframe_ext = 32'(req.load_frame_index);
    assign clr_ext    = 32'(clr_idx_reg);
    assign ev_ext     = 32'(frame_rd_reg.page);
    assign phys_ext   = (32'(page_rd_reg.frame) << PAGE_SHIFT) | 32'(offset_reg);

    assign req_bad = req.kind
        ? ((lpage_ext >= 32'(NUM_PAGES)) || (lframe_ext >= 32'(NUM_FRAMES)))
        : (vpn_ext >= 32'(NUM_PAGES));

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        page_we      = 1'b0;
        page_re      = 1'b0;
        page_waddr   = '0;
        page_raddr   = '0;
        page_wdata   = '0;
        frame_we     = 1'b0;
        frame_re     = 1'b0;
        frame_waddr  = '0;
        frame_raddr  = '0;
        frame_wdata  = '0;
        evt          = '0;
        load_out     = 1'b0;
        o_status     = STATUS_INVALID;
        o_phys       = '0;
        o_ev_valid   = 1'b0;
        o_ev_page    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                page_we     = (clr_ext < 32'(NUM_PAGES));
                page_waddr  = clr_ext[PIW-1:0];
                frame_we    = (clr_ext < 32'(NUM_FRAMES));
                frame_waddr = clr_ext[FW-1:0];
                if (clr_ext == 32'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_bad)
                    begin
                        state_next = S_LOOK;
                    end
                    else if (req.kind)
                    begin
                        frame_re    = 1'b1;
                        frame_raddr = lframe_ext[FW-1:0];
                        state_next  = S_UNMAP;
                    end
                    else
                    begin
                        page_re    = 1'b1;
                        page_raddr = vpn_ext[PIW-1:0];
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (bad_reg)
                    begin
                        o_status = STATUS_INVALID;
                    end
                    else if (page_rd_reg.present)
                    begin
                        o_status = STATUS_HIT;
                        o_phys   = phys_ext[PA_W-1:0];
                        evt.hit  = 1'b1;
                    end
                    else
                    begin
                        o_status  = STATUS_FAULT;
                        evt.fault = 1'b1;
                    end
                end
            end
            S_UNMAP:
            begin
                // Retarget the frame, unmap whichever page it named.
                frame_we          = 1'b1;
                frame_waddr       = lframe_reg;
                frame_wdata.valid = 1'b1;
                frame_wdata.page  = lpage_reg;
                if (frame_rd_reg.valid)
                begin
                    page_we    = 1'b1;
                    page_waddr = frame_rd_reg.page;
                end
                state_next = S_MAP;
            end
            S_MAP:
            begin
                if (out_free)
                begin
                    page_we            = 1'b1;
                    page_waddr         = lpage_reg;
                    page_wdata.present = 1'b1;
                    page_wdata.frame   = lframe_reg;
                    load_out           = 1'b1;
                    state_next         = S_IDLE;
                    o_status           = STATUS_LOADED;
                    o_ev_valid         = frame_rd_reg.valid;
                    o_ev_page          = frame_rd_reg.valid ? ev_ext[PAGE_IDX_W-1:0] : '0;
                end
            end
            default:
            begin
                state_next   = S_CLEAR;
                clr_idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_mem[page_waddr] <= page_wdata;
        end
        if (page_re)
        begin
            page_rd_reg <= page_mem[page_raddr];
        end
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re)
        begin
            frame_rd_reg <= frame_mem[frame_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bad_reg    <= req_bad;
            offset_reg <= req.vaddr[PAGE_SHIFT-1:0];
            lpage_reg  <= lpage_ext[PIW-1:0];
            lframe_reg <= lframe_ext[FW-1:0];
        end
        if (load_out)
        begin
            status_reg      <= o_status;
            phys_reg        <= o_phys;
            ev_valid_reg    <= o_ev_valid;
            ev_page_reg     <= o_ev_page;
            hit_total_reg   <= cnt_next.hits;
            fault_total_reg <= cnt_next.faults;
        end
    end

    ptl_stats u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .cnt_next (cnt_next)
    );

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.physical_address = phys_reg;
    assign rsp.evicted_valid    = ev_valid_reg;
    assign rsp.evicted_page     = ev_page_reg;
    assign rsp.hit_total        = hit_total_reg;
    assign rsp.fault_total      = fault_total_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("transaction accepted but sequencer stayed idle");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (page_we || frame_we) |-> !(page_re || frame_re))
        else $error("memory read issued during a write");

    a_translate_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STATUS_LOADED))
            |-> (!rsp.evicted_valid && (rsp.evicted_page == '0)))
        else $error("eviction reported on a non-load transaction");

    a_phys_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STATUS_HIT)) |-> (rsp.physical_address == '0))
        else $error("physical address set without a hit");

endmodule
